>>> design/iopic_pkg.sv
// Shared types and constants of the I/O port intercept checker.
`default_nettype none
package iopic_pkg;

  localparam int unsigned BITMAP_BYTES = 8192;
  localparam int unsigned BANK_ROWS    = BITMAP_BYTES / 2;
  localparam int unsigned ROW_W        = $clog2(BANK_ROWS);
  localparam int unsigned INDEX_W      = $clog2(BITMAP_BYTES);
  localparam int unsigned PORT_W       = 16;
  localparam int unsigned LEN_W        = 3;

  // Ports past the top of the port space: port + len above this exits when bitmaps are in use.
  localparam logic [PORT_W:0] PORT_SPACE = 17'h10000;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_CHECK = 1'b1;

  // Configuration register indexes
  localparam logic CFG_USE_BITMAPS = 1'b0;
  localparam logic CFG_EXIT_ALL    = 1'b1;

  // Address size codes
  localparam logic [1:0] ASZ_32 = 2'd1;
  localparam logic [1:0] ASZ_64 = 2'd2;

  typedef struct packed {
    logic                 req_type;
    logic [INDEX_W-1:0]   bitmap_index;
    logic [7:0]           bitmap_byte;
    logic [PORT_W-1:0]    port;
    logic [LEN_W-1:0]     access_len;
    logic                 is_in;
    logic                 is_string;
    logic                 has_immediate;
    logic                 rep_prefix;
    logic [2:0]           segment;
    logic [1:0]           addr_size;
  } in_req_t;

  typedef struct packed {
    logic        take_exit;
    logic [31:0] exit_qualification;
    logic [17:0] str_info;
    logic        str_info_valid;
  } out_rsp_t;

  // Access details carried down the pipeline
  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  access_len;
    logic              is_in;
    logic              is_string;
    logic              has_immediate;
    logic              rep_prefix;
    logic [2:0]        segment;
    logic [1:0]        addr_size;
  } acc_t;

  typedef struct packed {
    logic use_io_bitmaps;
    logic exit_all_io;
  } cfg_t;

  // Handshake between neighbouring stages
  typedef struct packed {
    logic valid;
    acc_t acc;
  } stage_t;

endpackage
`default_nettype wire

>>> design/iopic_fetch.sv
// Stage 1: banked bitmap store, write of bitmap bytes and read of two adjacent bytes.
`default_nettype none
module iopic_fetch
  import iopic_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire in_req_t in_req,
  input  wire logic    s2_ready,
  output stage_t       s1,
  output logic [7:0]   even_q,
  output logic [7:0]   odd_q
);

  logic [7:0]       bank_even [BANK_ROWS];
  logic [7:0]       bank_odd  [BANK_ROWS];
  logic             s1_valid_r;
  logic             s1_valid_nxt;
  acc_t             s1_acc_r;
  logic [7:0]       even_q_r;
  logic [7:0]       odd_q_r;
  logic             s1_ready;
  logic             take;
  logic             do_write;
  logic             do_read;
  logic [INDEX_W-1:0] rd_index;
  logic [ROW_W-1:0] even_row;
  logic [ROW_W-1:0] odd_row;
  logic [ROW_W-1:0] wr_row;

  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;
  assign take     = in_valid && s1_ready;
  assign do_write = take && (in_req.req_type == REQ_WRITE);
  assign do_read  = take && (in_req.req_type == REQ_CHECK);

  // Byte k and k+1 fall in opposite banks; the even one moves up a row when k is odd.
  assign rd_index = in_req.port[PORT_W-1:3];
  assign odd_row  = rd_index[INDEX_W-1:1];
  assign even_row = rd_index[0] ? (rd_index[INDEX_W-1:1] + ROW_W'(1)) : rd_index[INDEX_W-1:1];
  assign wr_row   = in_req.bitmap_index[INDEX_W-1:1];

  always_ff @(posedge clk) begin
    if (do_write && !in_req.bitmap_index[0]) begin
      bank_even[wr_row] <= in_req.bitmap_byte;
    end
    if (do_read) begin
      even_q_r <= bank_even[even_row];
    end
  end

  always_ff @(posedge clk) begin
    if (do_write && in_req.bitmap_index[0]) begin
      bank_odd[wr_row] <= in_req.bitmap_byte;
    end
    if (do_read) begin
      odd_q_r <= bank_odd[odd_row];
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_ready) begin
      s1_valid_nxt = do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      s1_acc_r <= '{port:          in_req.port,
                    access_len:    in_req.access_len,
                    is_in:         in_req.is_in,
                    is_string:     in_req.is_string,
                    has_immediate: in_req.has_immediate,
                    rep_prefix:    in_req.rep_prefix,
                    segment:       in_req.segment,
                    addr_size:     in_req.addr_size};
    end
  end

  assign s1.valid = s1_valid_r;
  assign s1.acc   = s1_acc_r;
  assign even_q   = even_q_r;
  assign odd_q    = odd_q_r;

endmodule
`default_nettype wire

>>> design/iopic_decide.sv
// Stage 2: mask the bitmap word, check for port wrap and decide the exit.
`default_nettype none
module iopic_decide
  import iopic_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire stage_t s1,
  input  wire logic [7:0] even_q,
  input  wire logic [7:0] odd_q,
  input  wire cfg_t   cfg,
  input  wire logic   s3_ready,
  output logic        s2_ready,
  output stage_t      s2,
  output logic        s2_exit
);

  logic        s2_valid_r;
  logic        s2_valid_nxt;
  acc_t        s2_acc_r;
  logic        s2_exit_r;
  logic        exit_nxt;
  logic [15:0] word;
  logic [7:0]  len_mask;
  logic [15:0] mask;
  logic        hit;
  logic        wrap;
  logic [PORT_W:0] port_end;

  assign s2_ready = !s2_valid_r || s3_ready;

  always_comb begin
    // Low byte of the word is the byte at port/8.
    word     = s1.acc.port[3] ? {even_q, odd_q} : {odd_q, even_q};
    len_mask = 8'((9'd1 << s1.acc.access_len) - 9'd1);
    mask     = {8'd0, len_mask} << s1.acc.port[2:0];
    hit      = |(word & mask);
    port_end = {1'b0, s1.acc.port} + (PORT_W+1)'(s1.acc.access_len);
    wrap     = port_end > PORT_SPACE;
    exit_nxt = cfg.use_io_bitmaps ? (wrap || hit) : cfg.exit_all_io;
  end

  always_comb begin
    s2_valid_nxt = s2_valid_r;
    if (s2_ready) begin
      s2_valid_nxt = s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1.valid) begin
      s2_acc_r  <= s1.acc;
      s2_exit_r <= exit_nxt;
    end
  end

  assign s2.valid = s2_valid_r;
  assign s2.acc   = s2_acc_r;
  assign s2_exit  = s2_exit_r;

endmodule
`default_nettype wire

>>> design/iopic_pack.sv
// Stage 3: build the exit qualification and instruction info into the output register.
`default_nettype none
module iopic_pack
  import iopic_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire stage_t s2,
  input  wire logic   s2_exit,
  output logic        s3_ready,
  output logic        out_valid,
  input  wire logic   out_stall,
  output out_rsp_t    out_rsp
);

  logic     out_valid_r;
  logic     out_valid_nxt;
  out_rsp_t out_rsp_r;
  out_rsp_t rsp_nxt;
  logic     str_exit;

  assign s3_ready = !out_valid_r || !out_stall;
  assign str_exit = s2_exit && s2.acc.is_string;

  always_comb begin
    rsp_nxt                = '0;
    rsp_nxt.take_exit      = s2_exit;
    rsp_nxt.str_info_valid = str_exit;
    if (s2_exit) begin
      rsp_nxt.exit_qualification = {s2.acc.port, 9'd0,
                                    s2.acc.has_immediate && !s2.acc.is_string,
                                    s2.acc.rep_prefix && s2.acc.is_string,
                                    s2.acc.is_string,
                                    s2.acc.is_in,
                                    s2.acc.access_len - LEN_W'(1)};
    end
    if (str_exit) begin
      rsp_nxt.str_info = {s2.acc.segment, 6'd0,
                          s2.acc.addr_size == ASZ_64,
                          s2.acc.addr_size == ASZ_32,
                          7'd0};
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s3_ready) begin
      out_valid_nxt = s2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2.valid) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire

>>> design/io_port_intercept_checker.sv
// Top level of the I/O port intercept checker: config registers and the three-stage pipeline.
//
// Usage:
//   Input channel (in_valid / in_stall / in_req): each request either writes one
//   byte of the combined 8192-byte I/O bitmap (req_type write) or checks one
//   guest I/O access (req_type check). Write requests produce no result.
//   Result channel (out_valid / out_stall / out_rsp): one response per check,
//   in request order, with the exit flag, qualification and string info.
//   Config port (cfg_we / cfg_index / cfg_wdata): index 0 use_io_bitmaps,
//   index 1 exit_all_io; write only while the pipeline is empty.
// Pipeline: stage 1 reads the two adjacent bitmap bytes from an even and an odd
//   bank, stage 2 masks them and decides the exit, stage 3 packs the response.
// Throughput: one request per cycle while in_stall is low, set by the single read port of each
//   bank; a write request issued in one cycle is seen by a check in the next.
// Reset (rst_n low, synchronous): empties the pipeline and clears both config
//   registers. The bitmap store is not cleared; load it before checking.
// Stall: out_stall holds the output register; bubbles ahead of it are
//   squeezed out before in_stall rises, so nothing is dropped or repeated.
`default_nettype none
module io_port_intercept_checker
  import iopic_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire in_req_t in_req,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_rsp_t     out_rsp,
  input  wire logic    cfg_we,
  input  wire logic    cfg_index,
  input  wire logic    cfg_wdata
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  stage_t     s1;
  stage_t     s2;
  logic [7:0] even_q;
  logic [7:0] odd_q;
  logic       s2_ready;
  logic       s3_ready;
  logic       s2_exit;

  // Config registers: hold unless written.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_USE_BITMAPS: cfg_nxt.use_io_bitmaps = cfg_wdata;
        CFG_EXIT_ALL:    cfg_nxt.exit_all_io    = cfg_wdata;
        default:         cfg_nxt                = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Stage 1: store writes, read the pair of bitmap bytes for checks.
  iopic_fetch u_fetch (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_req   (in_req),
    .s2_ready (s2_ready),
    .s1       (s1),
    .even_q   (even_q),
    .odd_q    (odd_q)
  );

  // Stage 2: mask and decide.
  iopic_decide u_decide (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1       (s1),
    .even_q   (even_q),
    .odd_q    (odd_q),
    .cfg      (cfg_r),
    .s3_ready (s3_ready),
    .s2_ready (s2_ready),
    .s2       (s2),
    .s2_exit  (s2_exit)
  );

  // Stage 3: pack the response into the output register.
  iopic_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .s2        (s2),
    .s2_exit   (s2_exit),
    .s3_ready  (s3_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

`ifndef SYNTH
  // A free output register must let the whole pipeline advance.
  a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // No exit means an empty qualification and no string info.
  a_quiet_when_no_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_rsp.take_exit) |->
      (out_rsp.exit_qualification == 32'd0 && !out_rsp.str_info_valid &&
       out_rsp.str_info == 18'd0))
    else $error("qualification set without an exit");

  // String info only comes with a string exit.
  a_info_is_string_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.str_info_valid) |->
      (out_rsp.take_exit && out_rsp.exit_qualification[4]))
    else $error("instruction info without a string exit");

  // With bitmaps off, the exit follows exit_all_io.
  a_exit_all_follows_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !cfg_r.use_io_bitmaps) |-> (out_rsp.take_exit == cfg_r.exit_all_io))
    else $error("exit disagrees with exit_all_io");
`endif

endmodule
`default_nettype wire
